/* hdl/bmse_pkg.sv */
// Shared constants, types and register codes of the biphase-mark sample encoder.
package bmse_pkg;

  localparam int MAX_SAMPLES   = 64;
  localparam int SAMPLE_MID    = 128;

  localparam int SAMPLE_W      = 8;
  localparam int COEFF_W       = 16;
  localparam int SPB_W         = 22;
  localparam int SPEED_W       = 16;
  localparam int SPEED_FRAC_W  = 12;
  localparam int REM_W         = 16;
  localparam int PROD_W        = SPB_W + SPEED_W;
  localparam int PER_W         = PROD_W - SPEED_FRAC_W;
  localparam int SUM_W         = PER_W + 1;
  localparam int LEN_RAW_W     = SUM_W - REM_W;
  localparam int LEN_W         = $clog2(MAX_SAMPLES + 1);
  localparam int RAMP_DEPTH    = MAX_SAMPLES / 2;
  localparam int RAMP_IDX_W    = $clog2(RAMP_DEPTH);

  localparam int JOBQ_DEPTH    = 2;
  localparam int JOBQ_AW       = $clog2(JOBQ_DEPTH);

  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = SPB_W;

  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_HIGH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_LOW   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FILTER      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPB         = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPHB        = 3'd4;

  localparam logic [SAMPLE_W-1:0] LEVEL_HIGH_RST = 8'd192;
  localparam logic [SAMPLE_W-1:0] LEVEL_LOW_RST  = 8'd64;
  localparam logic [SPB_W-1:0]    SPB_RST        = 22'd1310720;
  localparam logic [SPB_W-1:0]    SPHB_RST       = 22'd655360;

  typedef struct packed {
    logic [SAMPLE_W-1:0] level_high;
    logic [SAMPLE_W-1:0] level_low;
    logic [COEFF_W-1:0]  filter_coeff;
    logic [SPB_W-1:0]    samples_per_bit;
    logic [SPB_W-1:0]    samples_per_half_bit;
  } cfg_t;

  // One classified bit: segment lengths already cut to the per-bit limit.
  typedef struct packed {
    logic             err;
    logic             two_seg;
    logic             pol0;
    logic             clipped;
    logic [LEN_W-1:0] len0;
    logic [LEN_W-1:0] len1;
  } job_t;

endpackage

/* hdl/bmse_front.sv */
// Front end: accepts a bit, computes its segment lengths and polarity, queues a job unless the bit has no samples.
module bmse_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  bmse_pkg::cfg_t              cfg,
  input  logic                        in_push,
  output logic                        in_full,
  input  logic                        in_data_bit,
  input  logic [bmse_pkg::SPEED_W-1:0] in_speed_scale,
  output logic                        job_push,
  output bmse_pkg::job_t              job,
  input  logic                        job_full
);
  import bmse_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_SEG0, S_SEG1, S_PUSH} state_t;

  state_t                 state_r, state_nxt;
  logic [PER_W-1:0]       per_r, per_nxt;
  logic [REM_W-1:0]       rem_r, rem_nxt;
  logic                   pol_r, pol_nxt;
  logic                   pol0_r, pol0_nxt;
  logic                   two_r, two_nxt;
  logic                   err_r, err_nxt;
  logic [LEN_RAW_W-1:0]   len0_r, len0_nxt;
  logic [LEN_RAW_W-1:0]   len1_r, len1_nxt;

  logic                   accept;
  logic [PROD_W-1:0]      prod;
  logic [SUM_W-1:0]       sum;
  logic [LEN_W-1:0]       len0_cut, len1_cut, room1;
  logic                   clip;
  logic                   empty_bit;

  assign accept  = in_push && !in_full;
  assign in_full = (state_r != S_IDLE);

  always_comb begin
    prod = PROD_W'(in_data_bit ? cfg.samples_per_half_bit : cfg.samples_per_bit)
         * PROD_W'(in_speed_scale);
    sum  = SUM_W'(per_r) + SUM_W'(rem_r);

    len0_cut = (len0_r > LEN_RAW_W'(MAX_SAMPLES)) ? LEN_W'(MAX_SAMPLES)
                                                  : len0_r[LEN_W-1:0];
    room1    = LEN_W'(MAX_SAMPLES) - len0_cut;
    len1_cut = (len1_r > LEN_RAW_W'(room1)) ? room1 : len1_r[LEN_W-1:0];
    clip     = (len0_r > LEN_RAW_W'(MAX_SAMPLES)) || (len1_r > LEN_RAW_W'(room1));
    empty_bit = (len0_r == '0) && (len1_r == '0);

    job.err     = err_r;
    job.two_seg = two_r;
    job.pol0    = pol0_r;
    job.clipped = clip && !err_r;
    job.len0    = err_r ? '0 : len0_cut;
    job.len1    = err_r ? '0 : len1_cut;

    job_push = (state_r == S_PUSH) && !job_full && (err_r || !empty_bit);

    state_nxt = state_r;
    per_nxt   = per_r;
    rem_nxt   = rem_r;
    pol_nxt   = pol_r;
    pol0_nxt  = pol0_r;
    two_nxt   = two_r;
    err_nxt   = err_r;
    len0_nxt  = len0_r;
    len1_nxt  = len1_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          per_nxt  = prod[PROD_W-1:SPEED_FRAC_W];
          two_nxt  = in_data_bit;
          err_nxt  = (in_speed_scale == '0);
          len0_nxt = '0;
          len1_nxt = '0;
          state_nxt = (in_speed_scale == '0) ? S_PUSH : S_SEG0;
        end
      end
      S_SEG0: begin
        len0_nxt  = sum[SUM_W-1:REM_W];
        rem_nxt   = sum[REM_W-1:0];
        pol_nxt   = !pol_r;
        pol0_nxt  = !pol_r;
        state_nxt = two_r ? S_SEG1 : S_PUSH;
      end
      S_SEG1: begin
        len1_nxt  = sum[SUM_W-1:REM_W];
        rem_nxt   = sum[REM_W-1:0];
        pol_nxt   = !pol_r;
        state_nxt = S_PUSH;
      end
      S_PUSH: begin
        // a bit with no samples is dropped here; its state has advanced already
        if (job_push || (!err_r && empty_bit)) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      rem_r   <= '0;
      pol_r   <= 1'b0;
      err_r   <= 1'b0;
      two_r   <= 1'b0;
      len0_r  <= '0;
      len1_r  <= '0;
    end else begin
      state_r <= state_nxt;
      rem_r   <= rem_nxt;
      pol_r   <= pol_nxt;
      err_r   <= err_nxt;
      two_r   <= two_nxt;
      len0_r  <= len0_nxt;
      len1_r  <= len1_nxt;
    end
    per_r  <= per_nxt;
    pol0_r <= pol0_nxt;
  end

`ifndef SYNTHESIS
  a_job_len_total: assert property (@(posedge clk) disable iff (!rst_n)
    job_push && !job.err |->
      ((LEN_W+1)'(job.len0) + (LEN_W+1)'(job.len1) != '0) &&
      ((LEN_W+1)'(job.len0) + (LEN_W+1)'(job.len1) <= (LEN_W+1)'(MAX_SAMPLES)))
    else $error("front: job sample total out of range");
  a_err_job_empty: assert property (@(posedge clk) disable iff (!rst_n)
    job_push && job.err |-> job.len0 == '0 && job.len1 == '0 && !job.clipped)
    else $error("front: error job carries samples");
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r != S_IDLE)
    else $error("front: accepted item did not start work");
`endif

endmodule

/* hdl/bmse_job_fifo.sv */
// Short job queue between front and back.
module bmse_job_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  bmse_pkg::job_t din,
  output logic           full,
  input  logic           pop,
  output bmse_pkg::job_t dout,
  output logic           empty
);
  import bmse_pkg::*;

  job_t                 mem_r [JOBQ_DEPTH];
  logic [JOBQ_AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [JOBQ_AW:0]     count_r;

  assign full  = (count_r == (JOBQ_AW+1)'(JOBQ_DEPTH));
  assign empty = (count_r == '0);
  assign dout  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push && !full) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop && !empty) rd_ptr_r <= rd_ptr_r + 1'b1;
      case ({push && !full, pop && !empty})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) mem_r[wr_ptr_r] <= din;
  end

endmodule

/* hdl/bmse_back.sv */
// Back end: walks a job's segments, shapes each sample and holds the output register.
module bmse_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  bmse_pkg::cfg_t                cfg,
  input  logic                          job_empty,
  input  bmse_pkg::job_t                job_in,
  output logic                          job_pop,
  output logic                          out_empty,
  input  logic                          out_pop,
  output logic [bmse_pkg::SAMPLE_W-1:0] out_sample,
  output logic                          out_last_of_bit,
  output logic                          out_speed_error,
  output logic                          out_clipped
);
  import bmse_pkg::*;

  job_t                  job_r;
  logic                  act_r;
  logic                  seg_r;
  logic [LEN_W-1:0]      pos_r;
  logic [SAMPLE_W-1:0]   val_r;
  logic [SAMPLE_W-1:0]   ramp_r [RAMP_DEPTH];

  logic                  out_valid_r;
  logic [SAMPLE_W-1:0]   out_sample_r;
  logic                  out_last_r, out_err_r, out_clip_r;

  logic [LEN_W-1:0]      cur_len, half_len, mirror_idx;
  logic [SAMPLE_W-1:0]   level, step_val, ramp_rd, smp;
  logic signed [SAMPLE_W:0]            delta;
  logic signed [COEFF_W+SAMPLE_W+1:0]  acc;
  logic                  in_ramp, more_seg, seg_end, slot_free, fire, emit;

  always_comb begin
    cur_len    = seg_r ? job_r.len1 : job_r.len0;
    level      = (job_r.pol0 ^ seg_r) ? cfg.level_high : cfg.level_low;
    half_len   = LEN_W'(((LEN_W+1)'(cur_len) + 1'b1) >> 1);
    in_ramp    = pos_r < half_len;
    mirror_idx = cur_len - 1'b1 - pos_r;
    // first-order step: val + coeff*(level - val), Q0.16, never negative here
    delta      = $signed({1'b0, level}) - $signed({1'b0, val_r});
    acc        = $signed({2'b00, val_r, {COEFF_W{1'b0}}})
               + $signed({1'b0, cfg.filter_coeff}) * delta;
    step_val   = acc[COEFF_W +: SAMPLE_W];
    ramp_rd    = ramp_r[mirror_idx[RAMP_IDX_W-1:0]];
    smp        = (cfg.filter_coeff == '0) ? level : (in_ramp ? step_val : ramp_rd);
    more_seg   = !seg_r && job_r.two_seg && (job_r.len1 != '0);
    seg_end    = (pos_r == cur_len - 1'b1);
    slot_free  = !out_valid_r || out_pop;
    fire       = act_r && slot_free;
    emit       = fire && (job_r.err || (cur_len != '0));
    job_pop    = !act_r && !job_empty;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r       <= 1'b0;
      seg_r       <= 1'b0;
      pos_r       <= '0;
      val_r       <= SAMPLE_W'(SAMPLE_MID);
      out_valid_r <= 1'b0;
    end else begin
      if (out_pop && out_valid_r && !emit) out_valid_r <= 1'b0;
      if (job_pop) begin
        job_r <= job_in;
        act_r <= 1'b1;
        seg_r <= 1'b0;
        pos_r <= '0;
        val_r <= SAMPLE_W'(SAMPLE_MID);
      end else if (fire) begin
        if (job_r.err) begin
          out_valid_r  <= 1'b1;
          out_sample_r <= '0;
          out_last_r   <= 1'b0;
          out_err_r    <= 1'b1;
          out_clip_r   <= 1'b0;
          act_r        <= 1'b0;
        end else if (cur_len == '0) begin
          // empty first segment of a one bit: move on to the second half
          if (!seg_r && job_r.two_seg) begin
            seg_r <= 1'b1;
            pos_r <= '0;
            val_r <= SAMPLE_W'(SAMPLE_MID);
          end else begin
            act_r <= 1'b0;
          end
        end else begin
          out_valid_r  <= 1'b1;
          out_sample_r <= smp;
          out_last_r   <= seg_end && !more_seg;
          out_err_r    <= 1'b0;
          out_clip_r   <= job_r.clipped;
          if (in_ramp && !(seg_end && more_seg)) val_r <= step_val;
          if (seg_end) begin
            if (more_seg) begin
              seg_r <= 1'b1;
              pos_r <= '0;
              val_r <= SAMPLE_W'(SAMPLE_MID);
            end else begin
              act_r <= 1'b0;
            end
          end else begin
            pos_r <= pos_r + 1'b1;
          end
        end
      end
    end
  end

  // first half of a ramped segment is kept for its mirrored second half
  always_ff @(posedge clk) begin
    if (fire && !job_r.err && (cur_len != '0) && in_ramp) begin
      ramp_r[pos_r[RAMP_IDX_W-1:0]] <= step_val;
    end
  end

  assign out_empty       = !out_valid_r;
  assign out_sample      = out_sample_r;
  assign out_last_of_bit = out_last_r;
  assign out_speed_error = out_err_r;
  assign out_clipped     = out_clip_r;

`ifndef SYNTHESIS
  a_err_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_err_r |-> out_sample_r == '0 && !out_last_r && !out_clip_r)
    else $error("back: malformed speed error result");
  a_pos_in_seg: assert property (@(posedge clk) disable iff (!rst_n)
    act_r && !job_r.err && cur_len != '0 |-> pos_r < cur_len)
    else $error("back: sample position past segment end");
  a_job_start: assert property (@(posedge clk) disable iff (!rst_n)
    job_pop |=> act_r && pos_r == '0 && !seg_r)
    else $error("back: job not started cleanly");
`endif

endmodule

/* hdl/biphase_mark_sample_encoder_unit.sv */
// Biphase-mark sample encoder: config registers, front end, job queue and back end.
//
// Input channel: in_push / in_full carry one timecode bit (in_data_bit) and its
// speed (in_speed_scale, Q4.12). The front end multiplies in the accepting cycle,
// works out the first and, for a one bit, the second segment length, then queues
// the job, waiting while the queue is full; a zero-speed item goes straight to
// queueing. in_full is low only while the front end is idle.
// Result channel: out_empty / out_pop present the oldest sample with its
// last_of_bit, speed_error and clipped flags. The back end emits one sample per
// cycle from a registered output stage while the receiver keeps popping, up to 64
// per bit. A two-entry job queue lets the front end classify the next bit while
// the back end still plays out the previous one. With both idle, a bit passes the
// front end, the queue, the back end's job register and the output register before
// its first sample is out; a zero-speed item gives an error result instead. When the
// receiver stops popping, the output register holds, the back end waits, the queue
// fills and in_full stays high; nothing is lost.
// Configuration: cfg_valid / cfg_ready (always ready), cfg_index picks the register,
// cfg_data carries the value; write only while no bit is in flight.
// Reset (synchronous, rst_n low) restores register defaults, clears polarity and the
// length remainder and empties the queue and output stage.
module biphase_mark_sample_encoder_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_push,
  output logic                            in_full,
  input  logic                            in_data_bit,
  input  logic [bmse_pkg::SPEED_W-1:0]    in_speed_scale,
  output logic                            out_empty,
  input  logic                            out_pop,
  output logic [bmse_pkg::SAMPLE_W-1:0]   out_sample,
  output logic                            out_last_of_bit,
  output logic                            out_speed_error,
  output logic                            out_clipped,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bmse_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bmse_pkg::CFG_DATA_W-1:0] cfg_data
);
  import bmse_pkg::*;

  cfg_t  cfg_r;
  logic  job_push, job_full, job_pop, job_empty;
  job_t  job_wr, job_rd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.level_high           <= LEVEL_HIGH_RST;
      cfg_r.level_low            <= LEVEL_LOW_RST;
      cfg_r.filter_coeff         <= '0;
      cfg_r.samples_per_bit      <= SPB_RST;
      cfg_r.samples_per_half_bit <= SPHB_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_LEVEL_HIGH: cfg_r.level_high           <= cfg_data[SAMPLE_W-1:0];
        CFG_LEVEL_LOW:  cfg_r.level_low            <= cfg_data[SAMPLE_W-1:0];
        CFG_FILTER:     cfg_r.filter_coeff         <= cfg_data[COEFF_W-1:0];
        CFG_SPB:        cfg_r.samples_per_bit      <= cfg_data[SPB_W-1:0];
        CFG_SPHB:       cfg_r.samples_per_half_bit <= cfg_data[SPB_W-1:0];
        default: ;
      endcase
    end
  end

  bmse_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_data_bit    (in_data_bit),
    .in_speed_scale (in_speed_scale),
    .job_push       (job_push),
    .job            (job_wr),
    .job_full       (job_full)
  );

  bmse_job_fifo u_jobq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (job_push),
    .din   (job_wr),
    .full  (job_full),
    .pop   (job_pop),
    .dout  (job_rd),
    .empty (job_empty)
  );

  bmse_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .job_empty       (job_empty),
    .job_in          (job_rd),
    .job_pop         (job_pop),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_sample      (out_sample),
    .out_last_of_bit (out_last_of_bit),
    .out_speed_error (out_speed_error),
    .out_clipped     (out_clipped)
  );

endmodule
